>>> src/sinetq_pkg.sv
// types and constants for the quadrant-reduced taylor sine
// no dependencies
package sinetq_pkg;

  localparam logic [57:0] PI_Q56      = 58'h3243F6A8885A309;
  localparam logic [58:0] TWO_PI_Q56  = {PI_Q56, 1'b0};
  localparam logic [57:0] HALF_PI_Q56 = PI_Q56 >> 1;
  localparam logic [11:0] RECIP_2PI   = 12'd1304;
  localparam int          RECIP_SHIFT = 37;
  localparam int          DIV_SHIFT   = 35;
  localparam int          QDEPTH      = 4;
  localparam int          QAW         = $clog2(QDEPTH);

  typedef struct packed {
    logic        neg;
    logic [31:0] x;
  } red_t;

  typedef struct packed {
    logic               neg;
    logic [31:0]        x;
    logic [34:0]        term;
    logic [34:0]        n;
    logic signed [35:0] sum;
  } ser_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic int term_div(input int j);
    return (2 * j) * (2 * j + 1);
  endfunction

endpackage

>>> src/sinetq_ifs.sv
// stream interfaces for angle input and sine output
// no dependencies
interface angle_if;
  logic        valid;
  logic        ready;
  logic [31:0] angle;
  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

interface sine_if;
  logic        valid;
  logic        ready;
  logic [31:0] sine_value;
  modport source (output valid, output sine_value, input ready);
  modport sink (input valid, input sine_value, output ready);
endinterface

>>> src/sine_taylor_quadrant_reduced.sv
// sine of a q8.24 angle as q2.30 by quadrant reduction and taylor series
// pipeline: 7 front stages, the queue, then 4*TERMS+2 back stages
// throughput: one transaction per cycle while sine_out.ready does not stall the output, no dependence between items
// reset: synchronous active-high rst empties pipelines and queue
// depends on sinetq_pkg, sinetq_ifs, sinetq_front, sinetq_fifo, sinetq_back
module sine_taylor_quadrant_reduced import sinetq_pkg::*; #(
  parameter int TERMS = 5
) (
  input  logic   clk,
  input  logic   rst,
  angle_if.sink  angle_in,
  sine_if.source sine_out
);

  logic   push, pop;
  red_t   push_item, head;
  qstat_t qs;

  sinetq_front u_front (
    .clk, .rst, .angle_in, .q_full(qs.full), .push, .push_item
  );

  sinetq_fifo u_fifo (
    .clk, .rst, .push, .push_item, .pop, .head, .stat(qs)
  );

  sinetq_back #(.TERMS(TERMS)) u_back (
    .clk, .rst, .head, .head_valid(!qs.empty), .pop, .sine_out
  );

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    sine_out.valid |-> ($signed(sine_out.sine_value) <= 32'sd1073741824 &&
                        $signed(sine_out.sine_value) >= -32'sd1073741824))
    else $error("sine out of range");

  a_q_stat: assert property (@(posedge clk) disable iff (rst)
    !(qs.full && qs.empty))
    else $error("queue full and empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    qs.full && !pop |=> qs.full)
    else $error("queue lost entry");

endmodule

>>> src/sinetq_front.sv
// front end: modulo two pi reduction, quadrant fold and mirror to q1.31
// depends on sinetq_pkg and sinetq_ifs
module sinetq_front import sinetq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  angle_if.sink   angle_in,
  input  logic    q_full,
  output logic    push,
  output red_t    push_item
);

  logic               en;
  logic [7:1]         v;
  logic signed [31:0] a1, a2;
  logic signed [6:0]  k1;
  logic signed [65:0] prod2;
  logic signed [60:0] r3, r4;
  logic [58:0]        r5;
  logic [57:0]        r6;
  logic               neg6, neg7;
  logic [31:0]        x7;

  logic signed [43:0] kp;
  logic signed [65:0] r0w;
  logic signed [60:0] tp;
  logic [58:0]        rnd;
  logic [57:0]        mir;

  assign en             = !(v[7] && q_full);
  assign angle_in.ready = en;
  assign push           = v[7] && !q_full;
  assign push_item      = '{neg: neg7, x: x7};
  assign tp             = $signed({2'b00, TWO_PI_Q56});

  assign kp  = $signed({{12{angle_in.angle[31]}}, angle_in.angle}) *
               $signed({32'd0, RECIP_2PI});
  assign r0w = $signed({{2{a2[31]}}, a2, 32'd0}) - prod2;
  assign mir = (r6 >= HALF_PI_Q56) ? (PI_Q56 - r6) : r6;
  assign rnd = {1'b0, mir} + 59'd16777216;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[6:1], angle_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1    <= angle_in.angle;
      k1    <= kp[RECIP_SHIFT+6:RECIP_SHIFT];
      a2    <= a1;
      prod2 <= $signed({{59{k1[6]}}, k1}) * $signed({7'd0, TWO_PI_Q56});
      r3    <= r0w[60:0];
      if (r3 < 0) begin
        r4 <= r3 + tp;
      end else if (r3 >= tp) begin
        r4 <= r3 - tp;
      end else begin
        r4 <= r3;
      end
      if (r4 < 0) begin
        r5 <= 59'(r4 + tp);
      end else if (r4 >= tp) begin
        r5 <= 59'(r4 - tp);
      end else begin
        r5 <= r4[58:0];
      end
      if (r5 >= {1'b0, PI_Q56}) begin
        r6   <= 58'(r5 - {1'b0, PI_Q56});
        neg6 <= 1'b1;
      end else begin
        r6   <= r5[57:0];
        neg6 <= 1'b0;
      end
      x7   <= rnd[56:25];
      neg7 <= neg6;
    end
  end

endmodule

>>> src/sinetq_fifo.sv
// short queue between the reduction front end and the series back end
// depends on sinetq_pkg
module sinetq_fifo import sinetq_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  red_t   push_item,
  input  logic   pop,
  output red_t   head,
  output qstat_t stat
);

  red_t           mem [QDEPTH];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0]   cnt;

  assign stat.full  = (cnt == (QAW+1)'(QDEPTH));
  assign stat.empty = (cnt == '0);
  assign head       = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_item;
    end
  end

endmodule

>>> src/sinetq_back.sv
// back end: pipelined taylor series, clamp, scale to q2.30 and sign
// depends on sinetq_pkg and sinetq_ifs
module sinetq_back import sinetq_pkg::*; #(
  parameter int TERMS = 5
) (
  input  logic  clk,
  input  logic  rst,
  input  red_t  head,
  input  logic  head_valid,
  output logic  pop,
  sine_if.source sine_out
);

  localparam int NS = 4 * TERMS + 1;

  logic        en;
  logic [NS-1:0] v;
  ser_t        st [NS];
  logic        vo;
  logic [31:0] res;

  logic [31:0] clamped;
  logic [32:0] half;

  assign en  = !vo || sine_out.ready;
  assign pop = head_valid && en;
  assign sine_out.valid      = vo;
  assign sine_out.sine_value = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      v  <= '0;
      vo <= 1'b0;
    end else if (en) begin
      v  <= {v[NS-2:0], head_valid};
      vo <= v[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].neg  <= head.neg;
      st[0].x    <= head.x;
      st[0].term <= {3'd0, head.x};
      st[0].n    <= '0;
      st[0].sum  <= $signed({4'd0, head.x});
    end
  end

  for (genvar j = 1; j <= TERMS; j++) begin : g_term
    localparam int          D = term_div(j);
    localparam logic [32:0] M = 33'((64'd1 << DIV_SHIFT) / D);
    localparam int          B = 4 * (j - 1);

    logic [66:0]        pa, pb;
    logic [67:0]        pq;
    logic [35:0]        rem;
    logic [34:0]        qd;
    logic [34:0]        nn;
    logic [34:0]        qc;
    logic signed [35:0] sn;

    assign pa  = st[B].term * st[B].x + 67'd1073741824;
    assign pb  = st[B+1].term * st[B+1].x + 67'd1073741824;
    assign nn  = st[B+2].term + 35'(D / 2);
    assign pq  = nn * M;
    assign qd  = 35'(st[B+3].term * 35'(D));
    assign rem = {1'b0, st[B+3].n} - {1'b0, qd};
    assign qc  = (rem >= 36'(D)) ? st[B+3].term + 35'd1 : st[B+3].term;
    assign sn  = (j % 2 == 1) ? st[B+3].sum - $signed({1'b0, qc})
                              : st[B+3].sum + $signed({1'b0, qc});

    always_ff @(posedge clk) begin
      if (en) begin
        st[B+1] <= {st[B].neg, st[B].x, pa[65:31], st[B].n, st[B].sum};
        st[B+2] <= {st[B+1].neg, st[B+1].x, pb[65:31], st[B+1].n, st[B+1].sum};
        st[B+3] <= {st[B+2].neg, st[B+2].x, {2'd0, pq[67:35]}, nn, st[B+2].sum};
        st[B+4] <= {st[B+3].neg, st[B+3].x, qc, st[B+3].n, sn};
      end
    end
  end

  always_comb begin
    if (st[NS-1].sum < 0) begin
      clamped = '0;
    end else if (st[NS-1].sum > 36'sd2147483648) begin
      clamped = 32'h8000_0000;
    end else begin
      clamped = st[NS-1].sum[31:0];
    end
    half = ({1'b0, clamped} + 33'd1) >> 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= st[NS-1].neg ? (32'd0 - half[31:0]) : half[31:0];
    end
  end

endmodule
